>>> rtl/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared sizes, codes and request types for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Number of interleaved track streams and of MIDI channels.
  localparam int TRACK_COUNT      = 16;
  localparam int CHANNEL_COUNT    = 16;
  // Longest delay field, in 7-bit groups, before the value saturates.
  localparam int MAX_DELAY_GROUPS = 4;

  localparam int TRACK_W = 4;
  localparam int CHAN_W  = 4;
  localparam int ACC_W   = 28;
  localparam int GRP_W   = $clog2(MAX_DELAY_GROUPS + 1);
  localparam int WIDE_W  = 63;
  localparam int SHIFT_W = 6;

  localparam logic [ACC_W-1:0] ACC_MAX = 28'hFFF_FFFF;

  // Saturation value once the field has too many groups.
  localparam int SAT_BITS = (7 * MAX_DELAY_GROUPS >= ACC_W) ? ACC_W : 7 * MAX_DELAY_GROUPS;
  localparam logic [ACC_W-1:0] SAT_LIMIT = (SAT_BITS >= ACC_W) ? ACC_MAX :
                                           ACC_W'((64'd1 << SAT_BITS) - 64'd1);

  // Message patterns.
  localparam logic [23:0] END_OF_TRACK_MSG = 24'h002FFF;
  localparam logic [15:0] VOLUME_MASK      = 16'hFFF0;
  localparam logic [15:0] VOLUME_CTRL      = 16'h07B0;
  // Status nibbles at or below LONG_LO and at or above LONG_HI take three bytes.
  localparam logic [3:0]  LONG_LO          = 4'hB;
  localparam logic [3:0]  LONG_HI          = 4'hE;

  // Per-track parse phase.
  typedef enum logic [2:0] {
    PH_CMD0  = 3'd0,
    PH_CMD1  = 3'd1,
    PH_CMD2  = 3'd2,
    PH_DELAY = 3'd3,
    PH_ENDED = 3'd4
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_MESSAGE = 2'd0,
    KIND_DELAY   = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [7:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [TRACK_W-1:0] source_track;
    logic [23:0]        message;
    logic [30:0]        delay_ticks;
    logic               overflow;
    logic [7:0]         channel_volume;
  } out_item_t;

endpackage

>>> rtl/midi_track_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses interleaved track byte streams into messages, delays and end marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one byte request per
//   cycle when in_ready is high, tagged with its track number. Each track keeps
//   its own parse context, so bytes of different tracks may be interleaved freely.
//   Result channel (out_valid / out_ready / out_data) carries a completed
//   message, a completed delay (value times eight) or an end-of-track mark.
//   Bytes that only advance a track's context produce no result.
// Pipeline:
//   A request is taken into an input register, and its result then lands in
//   the output register (out_valid) when the output is not blocked.
//   One request is accepted per cycle unless a result is blocked; per-track
//   context is read and written by the single request in the input register.
// Reset:
//   rst_n clears every track to expecting its first command byte and clears
//   the channel volume cache. No clearing pass is needed.
// Stall:
//   While a result waits for out_ready, one more request may sit in the input
//   register; requests that produce no result still drain.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtep_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mtep_pkg::out_item_t out_data
);
  import mtep_pkg::*;

  // Input register.
  logic     in_valid_r;
  in_item_t in_r;

  // Per-track parse context.
  phase_t           ph_r   [TRACK_COUNT];
  logic [15:0]      part_r [TRACK_COUNT];
  logic [ACC_W-1:0] acc_r  [TRACK_COUNT];
  logic [GRP_W-1:0] gc_r   [TRACK_COUNT];
  logic             ovr_r  [TRACK_COUNT];

  // Channel volume cache.
  logic [7:0] vol_r [CHANNEL_COUNT];

  // Output register.
  logic      out_valid_r;
  out_item_t out_r;

  // Combinational step signals.
  logic [TRACK_W-1:0] trk;
  logic [7:0]         byte_in;
  logic               trk_ok;
  phase_t             ph_cur;
  logic [15:0]        part_cur;
  logic [ACC_W-1:0]   acc_cur;
  logic [GRP_W-1:0]   gc_cur;
  logic               ovr_cur;

  phase_t             ph_nxt;
  logic [15:0]        part_nxt;
  logic [ACC_W-1:0]   acc_nxt;
  logic [GRP_W-1:0]   gc_nxt;
  logic               ovr_nxt;

  logic [SHIFT_W-1:0] grp_shift;
  logic [WIDE_W-1:0]  grp_wide;
  logic               grp_fits;
  logic [ACC_W-1:0]   acc_step;
  logic               ovr_step;

  logic               fin;
  logic [23:0]        msg;
  logic               vol_we;
  logic               has_res;
  out_item_t          res;
  logic               adv;

  assign trk      = in_r.track;
  assign byte_in  = in_r.data_byte;
  assign trk_ok   = (32'(trk) < TRACK_COUNT);
  assign ph_cur   = ph_r[trk];
  assign part_cur = part_r[trk];
  assign acc_cur  = acc_r[trk];
  assign gc_cur   = gc_r[trk];
  assign ovr_cur  = ovr_r[trk];

  // Delay group accumulation: place the 7-bit group at its little-endian slot.
  assign grp_shift = SHIFT_W'(7 * int'(gc_cur));
  assign grp_wide  = WIDE_W'(byte_in[6:0]) << grp_shift;
  assign grp_fits  = (grp_shift < SHIFT_W'(ACC_W)) && (grp_wide <= WIDE_W'(ACC_MAX));

  always_comb begin
    acc_step = acc_cur;
    ovr_step = ovr_cur;
    if ((gc_cur < GRP_W'(MAX_DELAY_GROUPS)) && !ovr_cur) begin
      if (grp_fits) begin
        acc_step = acc_cur | grp_wide[ACC_W-1:0];
      end else if (byte_in[6:0] != 7'd0) begin
        acc_step = ACC_MAX;
        ovr_step = 1'b1;
      end
    end else begin
      acc_step = SAT_LIMIT;
      ovr_step = 1'b1;
    end
  end

  // Next context and result for the request in the input register.
  always_comb begin
    ph_nxt   = ph_cur;
    part_nxt = part_cur;
    acc_nxt  = acc_cur;
    gc_nxt   = gc_cur;
    ovr_nxt  = ovr_cur;
    fin      = 1'b0;
    msg      = '0;
    vol_we   = 1'b0;
    has_res  = 1'b0;
    res      = '0;
    res.source_track = trk;

    if (trk_ok) begin
      case (ph_cur)
        PH_CMD0: begin
          part_nxt = {8'h00, byte_in};
          ph_nxt   = PH_CMD1;
        end
        PH_CMD1: begin
          part_nxt = {byte_in, part_cur[7:0]};
          if ((part_cur[7:4] <= LONG_LO) || (part_cur[7:4] >= LONG_HI)) begin
            ph_nxt = PH_CMD2;
          end else begin
            fin = 1'b1;
            msg = {8'h00, byte_in, part_cur[7:0]};
          end
        end
        PH_CMD2: begin
          fin = 1'b1;
          msg = {byte_in, part_cur};
        end
        PH_DELAY: begin
          acc_nxt = acc_step;
          ovr_nxt = ovr_step;
          if ((gc_cur < GRP_W'(MAX_DELAY_GROUPS)) && !ovr_cur) begin
            gc_nxt = gc_cur + GRP_W'(1);
          end
          // Bit 7 closes the delay field.
          if (byte_in[7]) begin
            has_res         = 1'b1;
            res.kind        = KIND_DELAY;
            res.delay_ticks = {acc_step, 3'b000};
            res.overflow    = ovr_step;
            ph_nxt          = PH_CMD0;
            part_nxt        = '0;
            acc_nxt         = '0;
            gc_nxt          = '0;
            ovr_nxt         = 1'b0;
          end
        end
        default: begin
        end
      endcase

      // Completed command: end mark or message with volume lookup.
      if (fin) begin
        has_res = 1'b1;
        if (msg == END_OF_TRACK_MSG) begin
          ph_nxt   = PH_ENDED;
          res.kind = KIND_END;
        end else begin
          vol_we             = ((msg[15:0] & VOLUME_MASK) == VOLUME_CTRL);
          ph_nxt             = PH_DELAY;
          acc_nxt            = '0;
          gc_nxt             = '0;
          ovr_nxt            = 1'b0;
          res.kind           = KIND_MESSAGE;
          res.message        = msg;
          res.channel_volume = vol_we ? msg[23:16] : vol_r[msg[CHAN_W-1:0]];
        end
      end
    end
  end

  // Handshake: the input register advances unless its result would be blocked.
  assign adv      = in_valid_r && (!has_res || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= (in_valid && in_ready) || (in_valid_r && !adv);
    end
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Per-track context update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        ph_r[i]   <= PH_CMD0;
        part_r[i] <= '0;
        acc_r[i]  <= '0;
        gc_r[i]   <= '0;
        ovr_r[i]  <= 1'b0;
      end
    end else if (adv && trk_ok) begin
      ph_r[trk]   <= ph_nxt;
      part_r[trk] <= part_nxt;
      acc_r[trk]  <= acc_nxt;
      gc_r[trk]   <= gc_nxt;
      ovr_r[trk]  <= ovr_nxt;
    end
  end

  // Channel volume cache update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        vol_r[i] <= '0;
      end
    end else if (adv && vol_we) begin
      vol_r[msg[CHAN_W-1:0]] <= msg[23:16];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || (adv && has_res);
    end
    if (adv && has_res) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> verif/midi_track_event_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Watches both channels of the parser, keeps its own per-track parse
// context and channel volume cache, predicts the result of every accepted
// byte and compares each accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module midi_track_event_parser_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mtep_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mtep_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import mtep_pkg::*;

  // Message patterns and delay limits, taken from the parser's description.
  localparam logic [23:0] EOT_PATTERN   = 24'h002FFF;
  localparam logic [15:0] VOL_MASK      = 16'hFFF0;
  localparam logic [15:0] VOL_PATTERN   = 16'h07B0;
  localparam logic [63:0] DELAY_LIMIT   = 64'h0FFF_FFFF;
  localparam int          SAT_GROUP_W   = 7 * MAX_DELAY_GROUPS;
  localparam logic [63:0] DELAY_SAT     = (SAT_GROUP_W >= 28) ? DELAY_LIMIT :
                                          ((64'd1 << SAT_GROUP_W) - 64'd1);

  // Per-track parse context and the shared channel volume cache.
  phase_t      trk_phase  [TRACK_COUNT];
  logic [15:0] trk_cmd    [TRACK_COUNT];
  logic [63:0] trk_acc    [TRACK_COUNT];
  int          trk_groups [TRACK_COUNT];
  logic        trk_over   [TRACK_COUNT];
  logic [7:0]  chan_volume [CHANNEL_COUNT];

  out_item_t expected_events [$];

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                 int trk);
    fail_count++;
    $display("%0t MISMATCH %s on track %0d: got %0h, expected %0h",
             $time, what, trk, got, want);
  endtask

  // A command is complete: either the end mark or a message with its volume.
  task automatic finish_command(int t, logic [23:0] msg);
    out_item_t res;
    res = '0;
    res.source_track = 4'(t);
    if (msg == EOT_PATTERN) begin
      trk_phase[t] = PH_ENDED;
      res.kind = KIND_END;
    end else begin
      if ((msg[15:0] & VOL_MASK) == VOL_PATTERN) begin
        chan_volume[msg[3:0]] = msg[23:16];
      end
      trk_phase[t]  = PH_DELAY;
      trk_acc[t]    = '0;
      trk_groups[t] = 0;
      trk_over[t]   = 1'b0;
      res.kind           = KIND_MESSAGE;
      res.message        = msg;
      res.channel_volume = chan_volume[msg[3:0]];
    end
    expected_events.push_back(res);
  endtask

  // Advances one track by one byte and queues the result it causes, if any.
  task automatic parse_byte(in_item_t req);
    int          t;
    logic [7:0]  b;
    logic [63:0] acc;
    logic [63:0] grp;
    logic [63:0] ticks;
    int          n;
    int          sh;
    out_item_t   res;
    t = int'(req.track);
    b = req.data_byte;
    if (t < TRACK_COUNT) begin
      case (trk_phase[t])
        PH_CMD0: begin
          trk_cmd[t]   = {8'h00, b};
          trk_phase[t] = PH_CMD1;
        end
        PH_CMD1: begin
          trk_cmd[t][15:8] = b;
          // Status nibbles up to B and from E upward carry a third byte.
          if (trk_cmd[t][7:4] <= 4'hB || trk_cmd[t][7:4] >= 4'hE) begin
            trk_phase[t] = PH_CMD2;
          end else begin
            finish_command(t, {8'h00, trk_cmd[t]});
          end
        end
        PH_CMD2: begin
          finish_command(t, {b, trk_cmd[t]});
        end
        PH_DELAY: begin
          acc = trk_acc[t];
          n   = trk_groups[t];
          if (n < MAX_DELAY_GROUPS && !trk_over[t]) begin
            sh  = 7 * n;
            grp = {57'd0, b[6:0]};
            if (sh < 28 && (grp << sh) <= DELAY_LIMIT) begin
              acc = acc | (grp << sh);
              if (acc > DELAY_LIMIT) begin
                acc         = DELAY_LIMIT;
                trk_over[t] = 1'b1;
              end
            end else if (grp != 0) begin
              acc         = DELAY_LIMIT;
              trk_over[t] = 1'b1;
            end
            trk_groups[t] = n + 1;
          end else begin
            // Groups past the limit saturate the value.
            acc         = DELAY_SAT;
            trk_over[t] = 1'b1;
          end
          trk_acc[t] = acc;
          if (b[7]) begin
            ticks = acc << 3;
            res = '0;
            res.kind         = KIND_DELAY;
            res.source_track = 4'(t);
            res.delay_ticks  = ticks[30:0];
            res.overflow     = trk_over[t];
            expected_events.push_back(res);
            trk_phase[t]  = PH_CMD0;
            trk_cmd[t]    = '0;
            trk_acc[t]    = '0;
            trk_groups[t] = 0;
            trk_over[t]   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected result kind", 32'(got.kind), 32'hFFFF_FFFF,
                      int'(got.source_track));
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("kind", 32'(got.kind), 32'(want.kind),
                        int'(want.source_track));
      if (got.source_track !== want.source_track)
        report_mismatch("source_track", 32'(got.source_track), 32'(want.source_track),
                        int'(want.source_track));
      if (got.message !== want.message)
        report_mismatch("message", 32'(got.message), 32'(want.message),
                        int'(want.source_track));
      if (got.delay_ticks !== want.delay_ticks)
        report_mismatch("delay_ticks", 32'(got.delay_ticks), 32'(want.delay_ticks),
                        int'(want.source_track));
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow),
                        int'(want.source_track));
      if (got.channel_volume !== want.channel_volume)
        report_mismatch("channel_volume", 32'(got.channel_volume),
                        32'(want.channel_volume), int'(want.source_track));
    end
  endtask

  // Results are checked before requests are predicted; as the parser registers
  // input and result, no result belongs to a request taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        trk_phase[i]  = PH_CMD0;
        trk_cmd[i]    = '0;
        trk_acc[i]    = '0;
        trk_groups[i] = 0;
        trk_over[i]   = 1'b0;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_volume[i] = '0;
      end
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (in_valid && in_ready) begin
        parse_byte(in_data);
      end
    end
    pending <= expected_events.size();
  end

endmodule

>>> verif/midi_track_event_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds the parser a short directed set of events, then interleaved random
// track streams: mostly well-formed events with random content, plus stray
// bytes and cut-off events. The sender idles in bursts and the receiver
// stalls on its own pattern; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
  import mtep_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DIRECTED_N   = 26;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  // Directed requests as {track, byte}.
  logic [11:0] directed_items [DIRECTED_N] = '{
    // Lowest command bytes, three-byte form, zero delay.
    12'h0_00, 12'h0_00, 12'h0_00, 12'h0_80,
    // Volume controller on channel 15 at full level, one-group delay.
    12'h1_BF, 12'h1_07, 12'h1_FF, 12'h1_FF,
    // Two-byte program change, largest four-group delay.
    12'h2_C5, 12'h2_12, 12'h2_7F, 12'h2_7F, 12'h2_7F, 12'h2_FF,
    // Pitch bend on the top track, delay with one group too many.
    12'hF_E0, 12'hF_00, 12'hF_40,
    12'hF_00, 12'hF_00, 12'hF_00, 12'hF_00, 12'hF_81,
    // End of track, then a byte the ended track ignores.
    12'h6_FF, 12'h6_2F, 12'h6_00, 12'h6_12
  };

  logic [7:0] track_bytes [TRACK_COUNT][$];
  logic       track_alive [TRACK_COUNT];
  int         live_tracks;
  int         burst_left;
  int         calm_left;
  int         ready_step;
  logic       ready_free;
  logic [15:0] ready_pattern;
  int         quiet_cycles;

  midi_track_event_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  midi_track_event_parser_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: at the start of each window picks either free flow or a stall
  // pattern, now and then a pattern that stalls the whole window.
  always @(negedge clk) begin
    if (ready_step % 64 == 0) begin
      ready_free    = ($urandom_range(0, 3) == 0);
      ready_pattern = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    end
    out_ready <= ready_free || ready_pattern[ready_step % 16];
    ready_step++;
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one request; the sender works in bursts with gaps between them and
  // sometimes runs a long stretch with no gaps at all.
  task automatic send_item(in_item_t req);
    int gap;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(50, 150);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic track_open(int t);
    return track_alive[t] || track_bytes[t].size() != 0;
  endfunction

  // Queues one event for a track: a command (often a volume change, rarely
  // the end mark) and, but for the end mark, a delay field, now and then cut short.
  task automatic queue_event(int t);
    int         roll;
    int         groups;
    logic       all_ones;
    logic [7:0] status;
    logic [7:0] g;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      track_bytes[t].push_back(8'hB0 | 8'($urandom_range(0, 15)));
      track_bytes[t].push_back(8'h07);
      track_bytes[t].push_back(8'($urandom_range(0, 255)));
    end else if (roll < 17 && live_tracks > 10) begin
      track_bytes[t].push_back(8'hFF);
      track_bytes[t].push_back(8'h2F);
      track_bytes[t].push_back(8'h00);
      track_alive[t] = 1'b0;
      live_tracks--;
      return;
    end else begin
      status = (roll < 85) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
      track_bytes[t].push_back(status);
      track_bytes[t].push_back(8'($urandom));
      if (status[7:4] <= 4'hB || status[7:4] >= 4'hE) begin
        track_bytes[t].push_back(8'($urandom));
      end
    end
    roll     = $urandom_range(0, 99);
    all_ones = (roll >= 85);
    if (roll < 15) groups = MAX_DELAY_GROUPS + $urandom_range(1, 3);
    else if (all_ones) groups = MAX_DELAY_GROUPS;
    else groups = $urandom_range(1, MAX_DELAY_GROUPS);
    for (int i = 0; i < groups; i++) begin
      g = all_ones ? 8'h7F : 8'($urandom_range(0, 127));
      if (i == groups - 1) g[7] = 1'b1;
      track_bytes[t].push_back(g);
    end
    // A broken event: its tail never arrives.
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 2)) void'(track_bytes[t].pop_back());
    end
  endtask

  initial begin
    int       items_sent;
    int       t;
    int       last_track;
    logic     drained_once;
    in_item_t req;
    items_sent   = 0;
    last_track   = -1;
    drained_once = 1'b0;
    burst_left   = 0;
    calm_left    = 0;
    for (int i = 0; i < TRACK_COUNT; i++) track_alive[i] = 1'b1;
    live_tracks = TRACK_COUNT;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_item(in_item_t'(directed_items[i]));
    end
    track_alive[6] = 1'b0;
    live_tracks--;

    // Random part: interleaved tracks, often several bytes in a row from one.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 4) begin
        // Stray byte to any track, ended ones included.
        t = $urandom_range(0, TRACK_COUNT - 1);
        req.track     = 4'(t);
        req.data_byte = 8'($urandom);
        send_item(req);
        if (track_alive[t]) items_sent++;
      end else begin
        if (last_track >= 0 && track_open(last_track) && $urandom_range(0, 2) != 0) begin
          t = last_track;
        end else begin
          do t = $urandom_range(0, TRACK_COUNT - 1); while (!track_open(t));
        end
        if (track_bytes[t].size() == 0) queue_event(t);
        req.track     = 4'(t);
        req.data_byte = track_bytes[t].pop_front();
        send_item(req);
        last_track = t;
        items_sent++;
      end
      if (!drained_once && items_sent >= RANDOM_ITEMS / 2) begin
        drain_all();
        drained_once = 1'b1;
      end
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mtep_pkg.sv
rtl/midi_track_event_parser.sv
verif/midi_track_event_parser_checker.sv
verif/midi_track_event_parser_tb.sv
